### hw/rtl/slcan_pkg.sv
package slcan_pkg;

    // payload sizing
    localparam int MAX_DATA_BYTES = 8;
    localparam int ID_W           = 29;
    localparam int STD_ID_W       = 11;
    localparam int DLC_W          = 4;
    localparam int LEN_W          = 8;
    localparam int BITRATE_COUNT  = 9;

    // reply codes
    localparam logic [1:0] REPLY_FRAME = 2'd0;
    localparam logic [1:0] REPLY_ACK   = 2'd1;
    localparam logic [1:0] REPLY_ERROR = 2'd2;

    // command letters
    localparam logic [7:0] CMD_SET_BITRATE = 8'h53; // S
    localparam logic [7:0] CMD_OPEN        = 8'h4F; // O
    localparam logic [7:0] CMD_LISTEN      = 8'h4C; // L
    localparam logic [7:0] CMD_CLOSE       = 8'h43; // C
    localparam logic [7:0] CMD_STATUS      = 8'h46; // F
    localparam logic [7:0] CMD_SERIAL      = 8'h4E; // N
    localparam logic [7:0] CMD_VERSION     = 8'h56; // V
    localparam logic [7:0] CMD_VERSION_LC  = 8'h76; // v
    localparam logic [7:0] CMD_STD_DATA    = 8'h74; // t
    localparam logic [7:0] CMD_EXT_DATA    = 8'h54; // T
    localparam logic [7:0] CMD_STD_REMOTE  = 8'h72; // r
    localparam logic [7:0] CMD_EXT_REMOTE  = 8'h52; // R

    // ascii anchors
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_CR   = 8'h0D;

    // status flag bit positions
    localparam int FLAG_WARNING = 2;
    localparam int FLAG_FIFO    = 3;
    localparam int FLAG_PASSIVE = 5;
    localparam int FLAG_BUS_ERR = 7;

    // last error code that means "unchanged"
    localparam logic [2:0] LEC_UNCHANGED = 3'd7;

    // line lengths of frame commands without data
    localparam logic [LEN_W-1:0] STD_BASE_LEN = 8'd5;
    localparam logic [LEN_W-1:0] EXT_BASE_LEN = 8'd10;
    // position of the last identifier digit
    localparam logic [LEN_W-1:0] STD_ID_END   = 8'd3;
    localparam logic [LEN_W-1:0] EXT_ID_END   = 8'd8;
    // bitrate command lengths
    localparam logic [LEN_W-1:0] S_LEN_SHORT  = 8'd2;
    localparam logic [LEN_W-1:0] S_LEN_LONG   = 8'd5;

endpackage

### hw/rtl/slcan_command_line_decoder.sv
// Serial-line CAN command decoder. Takes one ASCII byte of a command line per
// transfer, with i_line_end on the last byte (no terminator is sent), and on
// that last byte gives one result: the reply code, the command letter, status
// flags, the bitrate index and bus-on flag after the line, and for t/T/r/R a
// CAN frame (identifier, DLC, data with byte i in bits 8i+7..8i). Bytes are
// taken one per clock: each one updates the line accumulators, and the result
// of a line sits in the output register from the cycle after its last byte.
// Bytes of the next line keep flowing while a result waits; only a last byte
// waits for the output register to be free.
module slcan_command_line_decoder #(
    parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_char_byte,
    input  logic                          i_line_end,
    input  logic                          i_tx_pending,
    input  logic                          i_error_warning,
    input  logic                          i_error_passive,
    input  logic                          i_rx_fifo_pending,
    input  logic [2:0]                    i_last_error_kind,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_reply_status,
    output logic [7:0]                    o_command_echo,
    output logic [7:0]                    o_status_flags,
    output logic                          o_frame_valid,
    output logic                          o_frame_extended,
    output logic                          o_frame_remote,
    output logic [slcan_pkg::ID_W-1:0]    o_frame_id,
    output logic [slcan_pkg::DLC_W-1:0]   o_frame_dlc,
    output logic [8*MAX_DATA_BYTES-1:0]   o_frame_data,
    output logic [3:0]                    o_bitrate_sel,
    output logic                          o_channel_open
);

    localparam int LEN_W    = slcan_pkg::LEN_W;
    localparam int ID_W     = slcan_pkg::ID_W;
    localparam int DLC_W    = slcan_pkg::DLC_W;
    localparam int DATA_W   = 8 * MAX_DATA_BYTES;
    localparam int NIBBLES  = 2 * MAX_DATA_BYTES;
    localparam int NIB_W    = $clog2(NIBBLES);
    localparam logic [LEN_W-1:0] LEN_MAX       = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] NIBBLES_L     = LEN_W'(NIBBLES);
    localparam logic [LEN_W-1:0] STD_MAX_LEN   = slcan_pkg::STD_BASE_LEN + NIBBLES_L;
    localparam logic [LEN_W-1:0] EXT_MAX_LEN   = slcan_pkg::EXT_BASE_LEN + NIBBLES_L;
    localparam logic [DLC_W-1:0] DLC_MAX       = DLC_W'(MAX_DATA_BYTES);

    // hex digit decode, carriage return counts as D
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c == slcan_pkg::ASCII_CR) begin
            res = {1'b1, 4'hD};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end
        return res;
    endfunction

    // channel state
    logic             r_bus_on;
    logic             r_init_done;
    logic [3:0]       r_bitrate;
    // line accumulators
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_letter;
    logic [7:0]       r_first_arg;
    logic             r_non_hex;
    logic [ID_W-1:0]  r_id;
    logic [DLC_W-1:0] r_dlc;
    logic [DATA_W-1:0] r_data;

    // next values after the current byte
    logic [LEN_W-1:0] n_len;
    logic [7:0]       n_letter;
    logic [7:0]       n_first_arg;
    logic             n_non_hex;
    logic [ID_W-1:0]  n_id;
    logic [DLC_W-1:0] n_dlc;
    logic [DATA_W-1:0] n_data;

    // result of a completed line
    logic             n_bus_on;
    logic             n_init_done;
    logic [3:0]       n_bitrate;
    logic [1:0]       n_reply;
    logic [7:0]       n_flags;
    logic             n_fv;
    logic             n_fx;
    logic             n_fr;
    logic [ID_W-1:0]  n_fid;
    logic [DLC_W-1:0] n_fdlc;
    logic [DATA_W-1:0] n_fdata;

    // output register
    logic             r_out_valid;
    logic [1:0]       r_reply;
    logic [7:0]       r_echo;
    logic [7:0]       r_flags;
    logic             r_fv;
    logic             r_fx;
    logic             r_fr;
    logic [ID_W-1:0]  r_fid;
    logic [DLC_W-1:0] r_fdlc;
    logic [DATA_W-1:0] r_fdata;
    logic [3:0]       r_out_bitrate;
    logic             r_out_open;

    logic             in_xfer;
    logic             line_done;
    logic [4:0]       hex;
    logic [3:0]       digit;
    logic             is_std;
    logic             is_ext;
    logic [LEN_W-1:0] id_end;
    logic [LEN_W-1:0] nib_pos;
    logic [NIB_W-1:0] nib_slot;

    // a last byte needs a free output register, other bytes always pass
    assign o_in_ready = !r_out_valid || i_out_ready || !i_line_end;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign line_done  = in_xfer && i_line_end;

    assign hex   = hex_decode(i_char_byte);
    assign digit = hex[3:0];

    // fold the byte into the line accumulators
    always_comb begin
        n_letter    = r_letter;
        n_first_arg = r_first_arg;
        n_non_hex   = r_non_hex;
        n_id        = r_id;
        n_dlc       = r_dlc;
        n_data      = r_data;
        is_std      = (n_letter == slcan_pkg::CMD_STD_DATA) ||
                      (n_letter == slcan_pkg::CMD_STD_REMOTE);
        is_ext      = (n_letter == slcan_pkg::CMD_EXT_DATA) ||
                      (n_letter == slcan_pkg::CMD_EXT_REMOTE);
        id_end      = is_ext ? slcan_pkg::EXT_ID_END : slcan_pkg::STD_ID_END;
        nib_pos     = r_len - id_end - LEN_W'(2);
        nib_slot    = {nib_pos[NIB_W-1:1], ~nib_pos[0]};
        if (r_len == '0) begin
            n_letter = i_char_byte;
            is_std   = 1'b0;
            is_ext   = 1'b0;
        end else begin
            if (!hex[4]) begin
                n_non_hex = 1'b1;
            end
            if (r_len == LEN_W'(1)) begin
                n_first_arg = i_char_byte;
            end
            if (is_std || is_ext) begin
                priority if (r_len <= id_end) begin
                    n_id = {r_id[ID_W-5:0], digit};
                end else if (r_len == id_end + LEN_W'(1)) begin
                    n_dlc = digit;
                end else begin
                    // digits past the last data byte are dropped
                    if (nib_pos < NIBBLES_L) begin
                        for (int j = 0; j < NIBBLES; j++) begin
                            if (nib_slot == NIB_W'(j)) begin
                                n_data[4*j +: 4] = r_data[4*j +: 4] | digit;
                            end
                        end
                    end
                end
            end
        end
        n_len = (r_len == LEN_MAX) ? r_len : r_len + LEN_W'(1);
    end

    // decide the outcome of the line
    always_comb begin
        logic [7:0]       sel;
        logic [LEN_W-1:0] base;
        logic [LEN_W-1:0] max_len;
        logic             ext;
        logic             rem;
        logic             ok;
        n_bus_on    = r_bus_on;
        n_init_done = r_init_done;
        n_bitrate   = r_bitrate;
        n_reply     = slcan_pkg::REPLY_ERROR;
        n_flags     = 8'd0;
        n_fv        = 1'b0;
        n_fx        = 1'b0;
        n_fr        = 1'b0;
        n_fid       = '0;
        n_fdlc      = '0;
        n_fdata     = '0;
        sel         = n_first_arg - slcan_pkg::ASCII_ZERO;
        ext         = (n_letter == slcan_pkg::CMD_EXT_DATA) ||
                      (n_letter == slcan_pkg::CMD_EXT_REMOTE);
        rem         = (n_letter == slcan_pkg::CMD_STD_REMOTE) ||
                      (n_letter == slcan_pkg::CMD_EXT_REMOTE);
        base        = ext ? slcan_pkg::EXT_BASE_LEN : slcan_pkg::STD_BASE_LEN;
        max_len     = ext ? EXT_MAX_LEN : STD_MAX_LEN;
        ok          = 1'b0;
        if (!n_non_hex) begin
            unique case (n_letter)
                slcan_pkg::CMD_SERIAL, slcan_pkg::CMD_VERSION,
                slcan_pkg::CMD_VERSION_LC: begin
                    n_reply = slcan_pkg::REPLY_ACK;
                end
                slcan_pkg::CMD_STATUS: begin
                    if (r_bus_on) begin
                        n_flags[slcan_pkg::FLAG_WARNING] = i_error_warning;
                        n_flags[slcan_pkg::FLAG_PASSIVE] = i_error_passive;
                        n_flags[slcan_pkg::FLAG_FIFO]    = i_rx_fifo_pending;
                        n_flags[slcan_pkg::FLAG_BUS_ERR] =
                            (i_last_error_kind != 3'd0) &&
                            (i_last_error_kind != slcan_pkg::LEC_UNCHANGED);
                    end
                    n_reply = slcan_pkg::REPLY_ACK;
                end
                slcan_pkg::CMD_SET_BITRATE: begin
                    if (!r_bus_on && (n_len == slcan_pkg::S_LEN_LONG ||
                                      n_len == slcan_pkg::S_LEN_SHORT) &&
                        sel < 8'(slcan_pkg::BITRATE_COUNT)) begin
                        n_bitrate   = sel[3:0];
                        n_init_done = 1'b1;
                        n_reply     = slcan_pkg::REPLY_ACK;
                    end
                end
                slcan_pkg::CMD_OPEN, slcan_pkg::CMD_LISTEN: begin
                    if (r_init_done && !r_bus_on) begin
                        n_bus_on = 1'b1;
                        n_reply  = slcan_pkg::REPLY_ACK;
                    end
                end
                slcan_pkg::CMD_CLOSE: begin
                    if (r_bus_on) begin
                        n_bus_on    = 1'b0;
                        n_init_done = 1'b0;
                        n_reply     = slcan_pkg::REPLY_ACK;
                    end
                end
                slcan_pkg::CMD_STD_DATA, slcan_pkg::CMD_EXT_DATA,
                slcan_pkg::CMD_STD_REMOTE, slcan_pkg::CMD_EXT_REMOTE: begin
                    if (r_bus_on && !i_tx_pending) begin
                        if (rem) begin
                            ok = (n_len == base);
                        end else begin
                            ok = (n_len >= base) && (n_len <= max_len) &&
                                 (LEN_W'(n_dlc) == ((n_len - base) >> 1)) &&
                                 (n_dlc <= DLC_MAX);
                        end
                    end
                    if (ok) begin
                        n_reply = slcan_pkg::REPLY_FRAME;
                        n_fv    = 1'b1;
                        n_fx    = ext;
                        n_fr    = rem;
                        n_fid   = ext ? n_id
                                      : {{(ID_W-slcan_pkg::STD_ID_W){1'b0}},
                                         n_id[slcan_pkg::STD_ID_W-1:0]};
                        n_fdlc  = n_dlc;
                        if (!rem) begin
                            for (int b = 0; b < MAX_DATA_BYTES; b++) begin
                                if (DLC_W'(b) < n_dlc) begin
                                    n_fdata[8*b +: 8] = n_data[8*b +: 8];
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_reply = slcan_pkg::REPLY_ERROR;
                end
            endcase
        end
    end

    // line accumulators and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_on    <= 1'b0;
            r_init_done <= 1'b0;
            r_bitrate   <= 4'd0;
            r_len       <= '0;
            r_letter    <= 8'd0;
            r_first_arg <= 8'd0;
            r_non_hex   <= 1'b0;
            r_id        <= '0;
            r_dlc       <= '0;
            r_data      <= '0;
        end else if (in_xfer) begin
            if (i_line_end) begin
                r_bus_on    <= n_bus_on;
                r_init_done <= n_init_done;
                r_bitrate   <= n_bitrate;
                r_len       <= '0;
                r_letter    <= 8'd0;
                r_first_arg <= 8'd0;
                r_non_hex   <= 1'b0;
                r_id        <= '0;
                r_dlc       <= '0;
                r_data      <= '0;
            end else begin
                r_len       <= n_len;
                r_letter    <= n_letter;
                r_first_arg <= n_first_arg;
                r_non_hex   <= n_non_hex;
                r_id        <= n_id;
                r_dlc       <= n_dlc;
                r_data      <= n_data;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (line_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (line_done) begin
            r_reply       <= n_reply;
            r_echo        <= n_letter;
            r_flags       <= n_flags;
            r_fv          <= n_fv;
            r_fx          <= n_fx;
            r_fr          <= n_fr;
            r_fid         <= n_fid;
            r_fdlc        <= n_fdlc;
            r_fdata       <= n_fdata;
            r_out_bitrate <= n_bitrate;
            r_out_open    <= n_bus_on;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_reply_status   = r_reply;
    assign o_command_echo   = r_echo;
    assign o_status_flags   = r_flags;
    assign o_frame_valid    = r_fv;
    assign o_frame_extended = r_fx;
    assign o_frame_remote   = r_fr;
    assign o_frame_id       = r_fid;
    assign o_frame_dlc      = r_fdlc;
    assign o_frame_data     = r_fdata;
    assign o_bitrate_sel    = r_out_bitrate;
    assign o_channel_open   = r_out_open;

`ifndef ASSERT_OFF
    // a frame result always carries the frame reply code
    a_frame_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_valid == (o_reply_status == slcan_pkg::REPLY_FRAME)))
        else $error("frame flag and reply code disagree");

    // a frame can only go out on an open channel
    a_frame_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_valid) |-> o_channel_open)
        else $error("frame emitted with channel closed");

    // status flags only come from a status query on an open channel
    a_flags_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status_flags != 8'd0) |->
            (o_command_echo == slcan_pkg::CMD_STATUS && o_channel_open))
        else $error("status flags set outside a status query");

    // line state is cleared after the last byte of a line
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_done |=> (r_len == '0 && !r_non_hex && r_data == '0))
        else $error("line state not cleared at line end");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int ID_W     = slcan_pkg::ID_W;
    localparam int DLC_W    = slcan_pkg::DLC_W;
    localparam int MAX_DB   = slcan_pkg::MAX_DATA_BYTES;

    // sideband sampled together with each byte
    typedef struct packed {
        logic       txp;
        logic       warn;
        logic       passive;
        logic       fifo;
        logic [2:0] lec;
    } t_side;

    // one decoded line as it appears on the result channel
    typedef struct packed {
        logic [1:0]          reply;
        logic [7:0]          echo;
        logic [7:0]          flags;
        logic                fv;
        logic                fx;
        logic                fr;
        logic [ID_W-1:0]     id;
        logic [DLC_W-1:0]    dlc;
        logic [8*MAX_DB-1:0] data;
        logic [3:0]          rate;
        logic                chan_open;
    } t_line_result;

    // directed table row; '_' stands for a zero byte and '^' for a carriage return
    typedef struct {
        string      text;
        int         fill;
        t_side      sb;
        bit         typed;
        logic [1:0] reply;
    } t_dir_row;

    localparam t_side SB_QUIET = '{1'b0, 1'b0, 1'b0, 1'b0, 3'd0};
    localparam t_side SB_BUSY  = '{1'b1, 1'b0, 1'b0, 1'b0, 3'd0};
    localparam t_side SB_ALL   = '{1'b0, 1'b1, 1'b1, 1'b1, 3'd3};
    localparam t_side SB_LEC7  = '{1'b0, 1'b1, 1'b0, 1'b1, slcan_pkg::LEC_UNCHANGED};
    localparam int    RANDOM_BYTES = 120;
    localparam int    OVERLONG_FILL = 251;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_in_valid        = 1'b0;
    logic                o_in_ready;
    logic [7:0]          i_char_byte       = 8'd0;
    logic                i_line_end        = 1'b0;
    logic                i_tx_pending      = 1'b0;
    logic                i_error_warning   = 1'b0;
    logic                i_error_passive   = 1'b0;
    logic                i_rx_fifo_pending = 1'b0;
    logic [2:0]          i_last_error_kind = 3'd0;
    logic                o_out_valid;
    logic                i_out_ready       = 1'b0;
    logic [1:0]          o_reply_status;
    logic [7:0]          o_command_echo;
    logic [7:0]          o_status_flags;
    logic                o_frame_valid;
    logic                o_frame_extended;
    logic                o_frame_remote;
    logic [ID_W-1:0]     o_frame_id;
    logic [DLC_W-1:0]    o_frame_dlc;
    logic [8*MAX_DB-1:0] o_frame_data;
    logic [3:0]          o_bitrate_sel;
    logic                o_channel_open;

    // decoder model state
    logic                chan_on    = 1'b0;
    logic                init_ok    = 1'b0;
    logic [3:0]          rate_idx   = 4'd0;
    logic [7:0]          line_len   = 8'd0;
    logic [7:0]          cur_letter = 8'd0;
    logic [7:0]          arg1_char  = 8'd0;
    logic                bad_hex    = 1'b0;
    logic [31:0]         id_acc     = 32'd0;
    logic [3:0]          dlc_acc    = 4'd0;
    logic [8*MAX_DB-1:0] data_acc   = '0;

    t_line_result result_q[$];
    t_dir_row     dir_rows[$];
    logic [7:0]   line_buf[$];
    int           bytes_taken  = 0;
    int           n_results    = 0;
    int           n_frames     = 0;
    int           n_err_replies = 0;
    int           error_count  = 0;
    bit           calm         = 1'b0;
    bit           typed_on     = 1'b0;
    logic [1:0]   typed_reply  = slcan_pkg::REPLY_ERROR;
    int           ready_left   = 0;

    slcan_command_line_decoder u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_char_byte       (i_char_byte),
        .i_line_end        (i_line_end),
        .i_tx_pending      (i_tx_pending),
        .i_error_warning   (i_error_warning),
        .i_error_passive   (i_error_passive),
        .i_rx_fifo_pending (i_rx_fifo_pending),
        .i_last_error_kind (i_last_error_kind),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_reply_status    (o_reply_status),
        .o_command_echo    (o_command_echo),
        .o_status_flags    (o_status_flags),
        .o_frame_valid     (o_frame_valid),
        .o_frame_extended  (o_frame_extended),
        .o_frame_remote    (o_frame_remote),
        .o_frame_id        (o_frame_id),
        .o_frame_dlc       (o_frame_dlc),
        .o_frame_data      (o_frame_data),
        .o_bitrate_sel     (o_bitrate_sel),
        .o_channel_open    (o_channel_open)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic mismatch(input string what);
        $display("MISMATCH @%0t result %0d: %s", $time, n_results, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // hex digit value; carriage return counts as D
    function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c == slcan_pkg::ASCII_CR) begin
            v = 4'd13;
            return 1'b1;
        end
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // fold one byte into the line state; returns 1 with the outcome on the last byte
    function automatic bit decode_byte(input logic [7:0] ch, input logic last,
                                       input t_side sb, output t_line_result r);
        logic [3:0] nib;
        logic [7:0] id_end;
        logic [7:0] pos;
        logic [7:0] len;
        logic [7:0] sel;
        logic [7:0] base;
        logic [7:0] top;
        int unsigned p;
        bit ext;
        bit rem;
        bit ok;
        r = '0;
        pos = line_len;
        if (pos == 8'd0) begin
            cur_letter = ch;
        end else begin
            if (!hex_value(ch, nib)) bad_hex = 1'b1;
            if (pos == 8'd1) arg1_char = ch;
            case (cur_letter)
                slcan_pkg::CMD_STD_DATA, slcan_pkg::CMD_STD_REMOTE:
                    id_end = slcan_pkg::STD_ID_END;
                slcan_pkg::CMD_EXT_DATA, slcan_pkg::CMD_EXT_REMOTE:
                    id_end = slcan_pkg::EXT_ID_END;
                default:
                    id_end = 8'd0;
            endcase
            if (id_end != 8'd0) begin
                if (pos <= id_end) begin
                    id_acc = {id_acc[27:0], nib};
                end else if (pos == id_end + 8'd1) begin
                    dlc_acc = nib;
                end else begin
                    // high nibble of each data byte comes first
                    p = pos - id_end - 8'd2;
                    if (p < 2 * MAX_DB) begin
                        data_acc |= 64'(nib) << (8 * (p >> 1) + ((p % 2 == 0) ? 4 : 0));
                    end
                end
            end
        end
        if (line_len != 8'hFF) line_len++;
        if (!last) return 1'b0;

        len = line_len;
        r.reply = slcan_pkg::REPLY_ERROR;
        r.echo = cur_letter;
        if (!bad_hex) begin
            case (cur_letter)
                slcan_pkg::CMD_SERIAL, slcan_pkg::CMD_VERSION,
                slcan_pkg::CMD_VERSION_LC: begin
                    r.reply = slcan_pkg::REPLY_ACK;
                end
                slcan_pkg::CMD_STATUS: begin
                    if (chan_on) begin
                        r.flags[slcan_pkg::FLAG_WARNING] = sb.warn;
                        r.flags[slcan_pkg::FLAG_PASSIVE] = sb.passive;
                        r.flags[slcan_pkg::FLAG_FIFO] = sb.fifo;
                        r.flags[slcan_pkg::FLAG_BUS_ERR] =
                            (sb.lec != 3'd0 && sb.lec != slcan_pkg::LEC_UNCHANGED);
                    end
                    r.reply = slcan_pkg::REPLY_ACK;
                end
                slcan_pkg::CMD_SET_BITRATE: begin
                    if (!chan_on && (len == slcan_pkg::S_LEN_LONG ||
                                     len == slcan_pkg::S_LEN_SHORT)) begin
                        sel = arg1_char - slcan_pkg::ASCII_ZERO;
                        if (sel <= slcan_pkg::BITRATE_COUNT - 1) begin
                            rate_idx = sel[3:0];
                            init_ok = 1'b1;
                            r.reply = slcan_pkg::REPLY_ACK;
                        end
                    end
                end
                slcan_pkg::CMD_OPEN, slcan_pkg::CMD_LISTEN: begin
                    if (init_ok && !chan_on) begin
                        chan_on = 1'b1;
                        r.reply = slcan_pkg::REPLY_ACK;
                    end
                end
                slcan_pkg::CMD_CLOSE: begin
                    if (chan_on) begin
                        chan_on = 1'b0;
                        init_ok = 1'b0;
                        r.reply = slcan_pkg::REPLY_ACK;
                    end
                end
                slcan_pkg::CMD_STD_DATA, slcan_pkg::CMD_EXT_DATA,
                slcan_pkg::CMD_STD_REMOTE, slcan_pkg::CMD_EXT_REMOTE: begin
                    ext = (cur_letter == slcan_pkg::CMD_EXT_DATA ||
                           cur_letter == slcan_pkg::CMD_EXT_REMOTE);
                    rem = (cur_letter == slcan_pkg::CMD_STD_REMOTE ||
                           cur_letter == slcan_pkg::CMD_EXT_REMOTE);
                    base = ext ? slcan_pkg::EXT_BASE_LEN : slcan_pkg::STD_BASE_LEN;
                    top = base + 8'(2 * MAX_DB);
                    ok = chan_on && !sb.txp;
                    if (ok) begin
                        if (rem) ok = (len == base);
                        else ok = (len >= base && len <= top &&
                                   {4'd0, dlc_acc} == (len - base) / 8'd2 &&
                                   dlc_acc <= MAX_DB);
                    end
                    if (ok) begin
                        r.reply = slcan_pkg::REPLY_FRAME;
                        r.fv = 1'b1;
                        r.fx = ext;
                        r.fr = rem;
                        r.id = ext ? id_acc[ID_W-1:0]
                                   : ID_W'(id_acc[slcan_pkg::STD_ID_W-1:0]);
                        r.dlc = dlc_acc;
                        if (!rem) begin
                            if (dlc_acc >= MAX_DB) r.data = data_acc;
                            else r.data = data_acc & ((64'd1 << (8 * dlc_acc)) - 64'd1);
                        end
                    end
                end
                default: ;
            endcase
        end
        r.rate = rate_idx;
        r.chan_open = chan_on;

        // line state starts over
        line_len = 8'd0;
        cur_letter = 8'd0;
        arg1_char = 8'd0;
        bad_hex = 1'b0;
        id_acc = 32'd0;
        dlc_acc = 4'd0;
        data_acc = '0;
        return 1'b1;
    endfunction

    // monitor: predict on byte transfers, compare on result transfers
    always @(posedge i_clk) begin
        t_line_result want;
        t_line_result got;
        t_side        sb;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb = '{i_tx_pending, i_error_warning, i_error_passive,
                       i_rx_fifo_pending, i_last_error_kind};
                if (decode_byte(i_char_byte, i_line_end, sb, want)) begin
                    if (typed_on) want.reply = typed_reply;
                    if (want.fv) n_frames++;
                    if (want.reply == slcan_pkg::REPLY_ERROR) n_err_replies++;
                    result_q.push_back(want);
                end
                bytes_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (result_q.size() == 0) begin
                    mismatch("result transfer with nothing expected");
                end else begin
                    want = result_q.pop_front();
                    got = '{o_reply_status, o_command_echo, o_status_flags,
                            o_frame_valid, o_frame_extended, o_frame_remote,
                            o_frame_id, o_frame_dlc, o_frame_data,
                            o_bitrate_sel, o_channel_open};
                    check_field("reply_status", 64'(got.reply), 64'(want.reply));
                    check_field("command_echo", 64'(got.echo), 64'(want.echo));
                    check_field("status_flags", 64'(got.flags), 64'(want.flags));
                    check_field("frame_valid", 64'(got.fv), 64'(want.fv));
                    check_field("frame_extended", 64'(got.fx), 64'(want.fx));
                    check_field("frame_remote", 64'(got.fr), 64'(want.fr));
                    check_field("frame_id", 64'(got.id), 64'(want.id));
                    check_field("frame_dlc", 64'(got.dlc), 64'(want.dlc));
                    check_field("frame_data", got.data, want.data);
                    check_field("bitrate_sel", 64'(got.rate), 64'(want.rate));
                    check_field("channel_open", 64'(got.chan_open), 64'(want.chan_open));
                end
            end
        end
    end

    // result side back-pressure: mostly short runs, some long stalls, some open stretches
    always @(negedge i_clk) begin
        int roll;
        if (ready_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                i_out_ready <= 1'b1;
                ready_left = $urandom_range(50, 150);
            end else if (roll < 60) begin
                i_out_ready <= 1'b1;
                ready_left = $urandom_range(1, 12);
            end else if (roll < 90) begin
                i_out_ready <= 1'b0;
                ready_left = $urandom_range(1, 3);
            end else begin
                i_out_ready <= 1'b0;
                ready_left = $urandom_range(10, 40);
            end
        end else begin
            ready_left--;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v == 4'd13 && $urandom_range(0, 7) == 0) return slcan_pkg::ASCII_CR;
        if (v < 4'd10) return slcan_pkg::ASCII_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    task automatic push_hex(input int count);
        int k;
        for (k = 0; k < count; k++) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
    endtask

    // send line_buf byte by byte; called and returns at a falling edge
    task automatic send_line(input t_side sb, input bit vary_side);
        int    k;
        int    gap;
        int    roll;
        int    target;
        t_side s;
        for (k = 0; k < line_buf.size(); k++) begin
            roll = $urandom_range(0, 99);
            if (calm || roll < 55) gap = 0;
            else if (roll < 90) gap = $urandom_range(1, 3);
            else gap = $urandom_range(8, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            s = sb;
            if (vary_side) begin
                s.txp = ($urandom_range(0, 7) == 0);
                s.warn = $urandom_range(0, 1);
                s.passive = $urandom_range(0, 1);
                s.fifo = $urandom_range(0, 1);
                s.lec = 3'($urandom_range(0, 7));
            end
            i_char_byte <= line_buf[k];
            i_line_end <= (k == line_buf.size() - 1);
            i_tx_pending <= s.txp;
            i_error_warning <= s.warn;
            i_error_passive <= s.passive;
            i_rx_fifo_pending <= s.fifo;
            i_last_error_kind <= s.lec;
            i_in_valid <= 1'b1;
            target = bytes_taken + 1;
            do @(negedge i_clk); while (bytes_taken < target);
        end
    endtask

    task automatic add_row(input string text, input int fill, input t_side sb,
                           input bit typed, input logic [1:0] reply);
        t_dir_row row;
        row.text = text;
        row.fill = fill;
        row.sb = sb;
        row.typed = typed;
        row.reply = reply;
        dir_rows.push_back(row);
    endtask

    // main stimulus
    initial begin
        int         i;
        int         k;
        int         roll;
        int         nbytes;
        int         dir_bytes;
        bit         ext;
        logic [7:0] ch;
        logic [1:0] rf;
        logic [1:0] ra;
        logic [1:0] re;

        rf = slcan_pkg::REPLY_FRAME;
        ra = slcan_pkg::REPLY_ACK;
        re = slcan_pkg::REPLY_ERROR;

        //      text                          fill           sideband  typed reply
        add_row("O",                          0,             SB_QUIET, 1, re);
        add_row("C",                          0,             SB_QUIET, 1, re);
        add_row("F",                          0,             SB_ALL,   1, ra);
        add_row("S9",                         0,             SB_QUIET, 1, re);
        add_row("S12",                        0,             SB_QUIET, 1, re);
        add_row("S0",                         0,             SB_QUIET, 1, ra);
        add_row("S8",                         0,             SB_QUIET, 1, ra);
        add_row("S3AbC",                      0,             SB_QUIET, 1, ra);
        add_row("O",                          0,             SB_QUIET, 1, ra);
        add_row("O",                          0,             SB_QUIET, 1, re);
        add_row("S5",                         0,             SB_QUIET, 1, re);
        add_row("F",                          0,             SB_ALL,   0, ra);
        add_row("F",                          0,             SB_LEC7,  0, ra);
        add_row("t7FF80123456789ABCDEF",      0,             SB_QUIET, 1, rf);
        add_row("t0000",                      0,             SB_QUIET, 1, rf);
        add_row("T1FFFFFFF8FEDCBA9876543210", 0,             SB_QUIET, 1, rf);
        add_row("TFFFFFFFF0",                 0,             SB_QUIET, 1, rf);
        add_row("r123F",                      0,             SB_QUIET, 1, rf);
        add_row("R0000ABCD^",                 0,             SB_QUIET, 0, rf);
        add_row("t1231ABC",                   0,             SB_QUIET, 0, rf);
        add_row("t1232AB",                    0,             SB_QUIET, 1, re);
        add_row("t1230",                      0,             SB_BUSY,  1, re);
        add_row("t12G0",                      0,             SB_QUIET, 1, re);
        add_row("N",                          0,             SB_QUIET, 1, ra);
        add_row("V",                          0,             SB_QUIET, 1, ra);
        add_row("v12",                        0,             SB_QUIET, 1, ra);
        add_row("N_",                         0,             SB_QUIET, 1, re);
        add_row("_",                          0,             SB_QUIET, 1, re);
        add_row("X",                          0,             SB_QUIET, 1, re);
        add_row("t1230",                      OVERLONG_FILL, SB_QUIET, 1, re);
        add_row("C",                          0,             SB_QUIET, 1, ra);
        add_row("L",                          0,             SB_QUIET, 1, re);
        add_row("S4",                         0,             SB_QUIET, 1, ra);
        add_row("L",                          0,             SB_QUIET, 1, ra);
        add_row("C",                          0,             SB_QUIET, 1, ra);

        // reset
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < dir_rows.size(); i++) begin
            line_buf.delete();
            for (k = 0; k < dir_rows[i].text.len(); k++) begin
                ch = dir_rows[i].text[k];
                if (ch == "_") ch = 8'h00;
                else if (ch == "^") ch = slcan_pkg::ASCII_CR;
                line_buf.push_back(ch);
            end
            repeat (dir_rows[i].fill) line_buf.push_back(slcan_pkg::ASCII_ZERO);
            calm = ($urandom_range(0, 2) == 0);
            typed_on = dir_rows[i].typed;
            typed_reply = dir_rows[i].reply;
            send_line(dir_rows[i].sb, 1'b0);
        end
        typed_on = 1'b0;
        dir_bytes = bytes_taken;

        // random lines, mostly well formed with the channel open
        while (bytes_taken - dir_bytes < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 5) == 0);
            if (!chan_on && $urandom_range(0, 3) != 0) begin
                line_buf = {slcan_pkg::CMD_SET_BITRATE,
                            slcan_pkg::ASCII_ZERO + 8'($urandom_range(0, 8))};
                send_line(SB_QUIET, 1'b1);
                line_buf = {($urandom_range(0, 1) ? slcan_pkg::CMD_OPEN
                                                  : slcan_pkg::CMD_LISTEN)};
                send_line(SB_QUIET, 1'b1);
            end
            line_buf.delete();
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                // data frame, sometimes with a wrong dlc or an odd trailing digit
                ext = $urandom_range(0, 1);
                line_buf.push_back(ext ? slcan_pkg::CMD_EXT_DATA : slcan_pkg::CMD_STD_DATA);
                push_hex(ext ? 8 : 3);
                nbytes = $urandom_range(0, MAX_DB);
                if ($urandom_range(0, 6) == 0) begin
                    line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
                end else begin
                    line_buf.push_back(hex_char(4'(nbytes)));
                end
                push_hex(2 * nbytes + (($urandom_range(0, 6) == 0) ? 1 : 0));
            end else if (roll < 55) begin
                // remote frame
                ext = $urandom_range(0, 1);
                line_buf.push_back(ext ? slcan_pkg::CMD_EXT_REMOTE
                                       : slcan_pkg::CMD_STD_REMOTE);
                push_hex(ext ? 8 : 3);
                push_hex(($urandom_range(0, 9) == 0) ? 2 : 1);
            end else if (roll < 63) begin
                line_buf = {slcan_pkg::CMD_SET_BITRATE,
                            slcan_pkg::ASCII_ZERO + 8'($urandom_range(0, 9))};
                if ($urandom_range(0, 3) == 0) push_hex(3);
                else if ($urandom_range(0, 3) == 0) push_hex($urandom_range(1, 4));
            end else if (roll < 70) begin
                line_buf = {($urandom_range(0, 1) ? slcan_pkg::CMD_OPEN
                                                  : slcan_pkg::CMD_LISTEN)};
            end else if (roll < 74) begin
                line_buf = {slcan_pkg::CMD_CLOSE};
            end else if (roll < 84) begin
                line_buf = {slcan_pkg::CMD_STATUS};
                if ($urandom_range(0, 7) == 0) push_hex(1);
            end else if (roll < 89) begin
                case ($urandom_range(0, 2))
                    0:       line_buf = {slcan_pkg::CMD_SERIAL};
                    1:       line_buf = {slcan_pkg::CMD_VERSION};
                    default: line_buf = {slcan_pkg::CMD_VERSION_LC};
                endcase
                if ($urandom_range(0, 3) == 0) push_hex($urandom_range(1, 4));
            end else begin
                // noise line
                nbytes = $urandom_range(1, 30);
                for (k = 0; k < nbytes; k++) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            // occasional corrupted argument byte
            if (line_buf.size() > 1 && $urandom_range(0, 11) == 0) begin
                line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
            send_line(SB_QUIET, 1'b1);
        end
        i_in_valid <= 1'b0;

        // drain
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("covered %0d bytes in %0d lines: %0d frames, %0d error replies",
                 bytes_taken, n_results, n_frames, n_err_replies);
        if (error_count == 0) begin
            $display("slcan_command_line_decoder regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("slcan_command_line_decoder regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("timeout with %0d results outstanding", result_q.size());
        $display("slcan_command_line_decoder regression: fail");
        $finish;
    end

endmodule
